// ===== hw/rtl/dhte_pkg.sv =====
`default_nettype none
package dhte_pkg;
    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_SEARCH = 2'd1,
        OP_DELETE = 2'd2,
        OP_UNUSED = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_INSERTED  = 3'd0,
        ST_DUPLICATE = 3'd1,
        ST_FOUND     = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_DELETED   = 3'd4,
        ST_FULL      = 3'd5,
        ST_BAD_KEY   = 3'd6
    } status_t;

    localparam int unsigned TABLE_SIZE  = 1024;
    localparam int unsigned IDX_W       = $clog2(TABLE_SIZE);
    localparam int unsigned STEP_PRIME  = 31;
    localparam int unsigned COUNT_W     = 11;
    localparam logic [COUNT_W-1:0] LOAD_LIMIT_RESET = 11'd512;

    // controller -> datapath
    typedef struct packed {
        logic clear;      // clear one key slot after reset
        logic load;       // capture request, start probe
        logic advance;    // go to next slot
        logic rd;         // read key/tomb at probe index
        logic wr_insert;  // write key + names at target
        logic wr_tomb;    // mark tombstone at hit slot
        logic rd_names;   // read names at hit slot
        logic done;       // emit result
        status_t status;
    } dhte_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic    clear_last;
        logic    bad_key;
        logic    full_limit;
        logic    slot_empty;
        logic    slot_hit;
        logic    last_try;
        logic    have_tomb;
        op_t     op;
    } dhte_stat_t;
endpackage
`default_nettype wire

// ===== hw/rtl/double_hash_table_engine_unit.sv =====
// Double-hashing lookup table. Pulse start while busy is low with op and key;
// insert also takes the names. One result appears for one cycle with
// result_valid high and cannot be stalled. After reset, busy stays high while
// the key and tombstone store is cleared one slot a cycle. A bad key or an
// insert refused at the load limit ends without a probe; a probe reads each
// slot and then evaluates it, with one more step to read the names on a
// search hit and one for an insert that makes 1024 probes without a match.
// A new request can be taken at the edge that takes the result.
`default_nettype none
module double_hash_table_engine_unit
    import dhte_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire logic [1:0]          op,
    input  wire logic [31:0]         key,
    input  wire logic [63:0]         first_name_lo,
    input  wire logic [63:0]         first_name_mid,
    input  wire logic [31:0]         first_name_hi,
    input  wire logic [63:0]         last_name_lo,
    input  wire logic [63:0]         last_name_mid,
    input  wire logic [31:0]         last_name_hi,
    input  wire logic                cfg_we,
    input  wire logic [COUNT_W-1:0]  cfg_data,
    output logic                     result_valid,
    output logic [2:0]               status,
    output logic [63:0]              found_first_lo,
    output logic [63:0]              found_first_mid,
    output logic [31:0]              found_first_hi,
    output logic [63:0]              found_last_lo,
    output logic [63:0]              found_last_mid,
    output logic [31:0]              found_last_hi,
    output logic [COUNT_W-1:0]       live_entries
);
    dhte_cmd_t  cmd;
    dhte_stat_t stat;

    dhte_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .stat  (stat),
        .cmd   (cmd)
    );

    dhte_datapath u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .stat            (stat),
        .op              (op),
        .key             (key),
        .first_name_lo   (first_name_lo),
        .first_name_mid  (first_name_mid),
        .first_name_hi   (first_name_hi),
        .last_name_lo    (last_name_lo),
        .last_name_mid   (last_name_mid),
        .last_name_hi    (last_name_hi),
        .cfg_we          (cfg_we),
        .cfg_data        (cfg_data),
        .done            (result_valid),
        .status          (status),
        .found_first_lo  (found_first_lo),
        .found_first_mid (found_first_mid),
        .found_first_hi  (found_first_hi),
        .found_last_lo   (found_last_lo),
        .found_last_mid  (found_last_mid),
        .found_last_hi   (found_last_hi),
        .live_entries    (live_entries)
    );
endmodule
`default_nettype wire

// ===== hw/rtl/dhte_datapath.sv =====
`default_nettype none
module dhte_datapath
    import dhte_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire dhte_cmd_t           cmd,
    output dhte_stat_t               stat,
    input  wire logic [1:0]          op,
    input  wire logic [31:0]         key,
    input  wire logic [63:0]         first_name_lo,
    input  wire logic [63:0]         first_name_mid,
    input  wire logic [31:0]         first_name_hi,
    input  wire logic [63:0]         last_name_lo,
    input  wire logic [63:0]         last_name_mid,
    input  wire logic [31:0]         last_name_hi,
    input  wire logic                cfg_we,
    input  wire logic [COUNT_W-1:0]  cfg_data,
    output logic                     done,
    output logic [2:0]               status,
    output logic [63:0]              found_first_lo,
    output logic [63:0]              found_first_mid,
    output logic [31:0]              found_first_hi,
    output logic [63:0]              found_last_lo,
    output logic [63:0]              found_last_mid,
    output logic [31:0]              found_last_hi,
    output logic [COUNT_W-1:0]       live_entries
);
    localparam int unsigned CNT_W = IDX_W + 1;

    // bit 32 marks a tombstone; cleared by a pass after reset
    logic [32:0]  key_mem [TABLE_SIZE];
    logic [63:0]  name_mem [TABLE_SIZE][5];

    logic [1:0]        op_reg;
    logic [31:0]       key_reg;
    logic [63:0]       w0_reg, w1_reg, w2_reg, w3_reg, w4_reg;
    logic [IDX_W-1:0]  idx_reg, tomb_idx_reg, clr_idx_reg;
    logic [4:0]        step_reg;
    logic [CNT_W-1:0]  tries_reg;
    logic              have_tomb_reg;
    logic [32:0]       rd_key_reg;
    logic [COUNT_W-1:0] live_reg, limit_reg;
    logic [63:0]       rn [5];

    logic [IDX_W:0]    idx_sum;
    logic [IDX_W-1:0]  idx_nxt;
    logic [7:0]        fold1;
    logic [5:0]        fold2;
    logic [4:0]        fold3;
    logic [4:0]        kmod31;
    logic [IDX_W-1:0]  tgt;

    // key mod 31 by summing 5-bit digits (32 == 1 mod 31)
    assign fold1   = 8'(key[4:0]) + 8'(key[9:5]) + 8'(key[14:10]) + 8'(key[19:15])
                   + 8'(key[24:20]) + 8'(key[29:25]) + 8'(key[31:30]);
    assign fold2   = 6'(fold1[4:0]) + 6'(fold1[7:5]);
    assign fold3   = fold2[4:0] + 5'(fold2[5]);
    assign kmod31  = (fold3 == 5'd31) ? 5'd0 : fold3;
    assign idx_sum = {1'b0, idx_reg} + (IDX_W+1)'(step_reg);
    assign idx_nxt = (idx_sum >= (IDX_W+1)'(TABLE_SIZE)) ?
                     IDX_W'(idx_sum - (IDX_W+1)'(TABLE_SIZE)) : idx_sum[IDX_W-1:0];
    assign tgt     = have_tomb_reg ? tomb_idx_reg : idx_reg;

    always_comb
    begin
        stat.clear_last = (clr_idx_reg == IDX_W'(TABLE_SIZE - 1));
        stat.bad_key    = (key_reg == 32'd0);
        stat.full_limit = (live_reg >= limit_reg);
        stat.slot_empty = (rd_key_reg[31:0] == 32'd0);
        stat.slot_hit   = (rd_key_reg[31:0] == key_reg) && !rd_key_reg[32];
        stat.last_try   = (tries_reg == CNT_W'(TABLE_SIZE - 1));
        stat.have_tomb  = have_tomb_reg;
        stat.op         = op_t'(op_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_idx_reg <= '0;
            live_reg    <= '0;
            limit_reg   <= LOAD_LIMIT_RESET;
            done        <= 1'b0;
        end
        else
        begin
            done <= cmd.done;
            if (cmd.clear)
                clr_idx_reg <= clr_idx_reg + 1'b1;
            if (cfg_we)
                limit_reg <= cfg_data;
            if (cmd.wr_insert)
                live_reg <= live_reg + 1'b1;
            if (cmd.wr_tomb)
                live_reg <= live_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg        <= op;
            key_reg       <= key;
            w0_reg        <= first_name_lo;
            w1_reg        <= first_name_mid;
            w2_reg        <= {last_name_hi, first_name_hi};
            w3_reg        <= last_name_lo;
            w4_reg        <= last_name_mid;
            idx_reg       <= key[IDX_W-1:0];
            step_reg      <= 5'(STEP_PRIME) - kmod31;
            tries_reg     <= '0;
            have_tomb_reg <= 1'b0;
        end
        if (cmd.advance)
        begin
            if (rd_key_reg[32] && !have_tomb_reg)
            begin
                have_tomb_reg <= 1'b1;
                tomb_idx_reg  <= idx_reg;
            end
            idx_reg   <= idx_nxt;
            tries_reg <= tries_reg + 1'b1;
        end
        if (cmd.rd)
            rd_key_reg <= key_mem[idx_reg];
        if (cmd.clear)
            key_mem[clr_idx_reg] <= '0;
        if (cmd.wr_tomb)
            key_mem[idx_reg] <= {1'b1, key_reg};
        if (cmd.wr_insert)
        begin
            key_mem[tgt]     <= {1'b0, key_reg};
            name_mem[tgt][0] <= w0_reg;
            name_mem[tgt][1] <= w1_reg;
            name_mem[tgt][2] <= w2_reg;
            name_mem[tgt][3] <= w3_reg;
            name_mem[tgt][4] <= w4_reg;
        end
        if (cmd.rd_names)
        begin
            for (int i = 0; i < 5; i++)
                rn[i] <= name_mem[idx_reg][i];
        end
        if (cmd.done)
            status <= cmd.status;
    end

    logic found_q;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            found_q <= 1'b0;
        else if (cmd.done)
            found_q <= (cmd.status == ST_FOUND);
    end

    always_comb
    begin
        found_first_lo  = found_q ? rn[0] : 64'd0;
        found_first_mid = found_q ? rn[1] : 64'd0;
        found_first_hi  = found_q ? rn[2][31:0] : 32'd0;
        found_last_lo   = found_q ? rn[3] : 64'd0;
        found_last_mid  = found_q ? rn[4] : 64'd0;
        found_last_hi   = found_q ? rn[2][63:32] : 32'd0;
        live_entries    = live_reg;
    end
endmodule
`default_nettype wire

// ===== hw/rtl/dhte_ctrl.sv =====
`default_nettype none
module dhte_ctrl
    import dhte_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    output logic            busy,
    input  wire dhte_stat_t stat,
    output dhte_cmd_t       cmd
);
    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_CHECK, S_READ, S_EVAL, S_NAMES, S_DONE
    } state_t;

    state_t  state_reg, state_next;
    status_t st_reg, st_next;

    always_comb
    begin
        state_next    = state_reg;
        st_next       = st_reg;
        cmd           = '0;
        cmd.status    = st_reg;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (stat.clear_last)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (stat.bad_key)
                begin
                    st_next    = ST_BAD_KEY;
                    state_next = S_DONE;
                end
                else if (stat.op == OP_INSERT && stat.full_limit)
                begin
                    st_next    = ST_FULL;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.rd     = 1'b1;
                    state_next = S_EVAL;
                end
            end
            S_READ:
            begin
                cmd.rd     = 1'b1;
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                if (stat.slot_empty)
                begin
                    if (stat.op == OP_INSERT)
                    begin
                        cmd.wr_insert = 1'b1;
                        st_next       = ST_INSERTED;
                    end
                    else
                        st_next = ST_NOT_FOUND;
                    state_next = S_DONE;
                end
                else if (stat.slot_hit)
                begin
                    case (stat.op)
                        OP_INSERT:
                        begin
                            st_next    = ST_DUPLICATE;
                            state_next = S_DONE;
                        end
                        OP_DELETE:
                        begin
                            cmd.wr_tomb = 1'b1;
                            st_next     = ST_DELETED;
                            state_next  = S_DONE;
                        end
                        default:
                        begin
                            cmd.rd_names = 1'b1;
                            st_next      = ST_FOUND;
                            state_next   = S_NAMES;
                        end
                    endcase
                end
                else if (stat.last_try)
                begin
                    cmd.advance = 1'b1;
                    if (stat.op == OP_INSERT)
                    begin
                        // tombstone captured during this advance is not yet visible
                        st_next    = ST_FULL;
                        state_next = S_NAMES;
                    end
                    else
                    begin
                        st_next    = ST_NOT_FOUND;
                        state_next = S_DONE;
                    end
                end
                else
                begin
                    cmd.advance = 1'b1;
                    state_next  = S_READ;
                end
            end
            S_NAMES:
            begin
                if (st_reg == ST_FULL && stat.have_tomb)
                begin
                    cmd.wr_insert = 1'b1;
                    st_next       = ST_INSERTED;
                end
                state_next = S_DONE;
            end
            S_DONE:
            begin
                cmd.done   = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            st_reg    <= ST_NOT_FOUND;
        end
        else
        begin
            state_reg <= state_next;
            st_reg    <= st_next;
        end
    end

    assign busy = (state_reg != S_IDLE);
endmodule
`default_nettype wire

// ===== hw/rtl/dhte_checker.sv =====
`default_nettype none
module dhte_checker
    import dhte_pkg::*;
(
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               start,
    input wire logic               busy,
    input wire logic               result_valid,
    input wire logic [2:0]         status,
    input wire logic [63:0]        found_first_lo,
    input wire logic [COUNT_W-1:0] live_entries
);
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy) else $error("request not taken");
    a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !busy) else $error("result while busy");
    a_one_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !result_valid) else $error("result repeated");
    a_zero_names: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && status != ST_FOUND |-> found_first_lo == 64'd0)
        else $error("names not zero");
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        !result_valid |=> $stable(live_entries) || $past(busy))
        else $error("count moved while idle");
endmodule

bind double_hash_table_engine_unit dhte_checker u_dhte_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .result_valid   (result_valid),
    .status         (status),
    .found_first_lo (found_first_lo),
    .live_entries   (live_entries)
);
`default_nettype wire
